// File: design/pcf_pkg.sv
`default_nettype none

package pcf_pkg;

   localparam int LEN_WIDTH  = 31;
   localparam int TYPE_WIDTH = 32;
   localparam int BYTE_WIDTH = 8;
   localparam int CRC_WIDTH  = 32;
   localparam int STEP_WIDTH = 4;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'hEDB88320;
   localparam logic [CRC_WIDTH-1:0] CRC_ONES = 32'hFFFFFFFF;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Output byte positions within one queued operation.
   localparam logic [STEP_WIDTH-1:0] STEP_TYPE_FIRST = 4'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_CRC_FIRST  = 4'd8;
   localparam logic [STEP_WIDTH-1:0] STEP_BEGIN_LAST = 4'd7;
   localparam logic [STEP_WIDTH-1:0] STEP_EMPTY_LAST = 4'd11;
   localparam logic [STEP_WIDTH-1:0] STEP_DATA_LAST  = 4'd4;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_ERROR       = 3'd0,
      OP_BEGIN       = 3'd1,
      OP_BEGIN_EMPTY = 3'd2,
      OP_DATA        = 3'd3,
      OP_DATA_LAST   = 3'd4
   } pcf_op_type;

   typedef struct packed {
      pcf_op_type                  op;
      logic [LEN_WIDTH-1:0]        chunk_length;
      logic [TYPE_WIDTH-1:0]       chunk_type;
      logic [BYTE_WIDTH-1:0]       data_byte;
   } pcf_entry_type;

   // One entry of the reflected CRC-32 byte table.
   function automatic logic [CRC_WIDTH-1:0] crc_table(input logic [BYTE_WIDTH-1:0] idx);
      logic [CRC_WIDTH-1:0] c;
      c = {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, idx};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [CRC_WIDTH-1:0] crc_fold(input logic [CRC_WIDTH-1:0] c,
                                                    input logic [BYTE_WIDTH-1:0] b);
      return (c >> BYTE_WIDTH) ^ crc_table(c[BYTE_WIDTH-1:0] ^ b);
   endfunction

   // Big-endian byte select: index 0 is bits 31..24.
   function automatic logic [BYTE_WIDTH-1:0] be_byte(input logic [31:0] w,
                                                    input logic [1:0] idx);
      logic [BYTE_WIDTH-1:0] b;
      case (idx)
         2'd0:    b = w[31:24];
         2'd1:    b = w[23:16];
         2'd2:    b = w[15:8];
         default: b = w[7:0];
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: design/pcf_req_if.sv
`default_nettype none

interface pcf_req_if
   import pcf_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [LEN_WIDTH-1:0]  chunk_length;
   logic [TYPE_WIDTH-1:0] chunk_type;
   logic [BYTE_WIDTH-1:0] data_byte;

   modport source (output valid, output cmd, output chunk_length, output chunk_type,
                   output data_byte, input ready);
   modport sink (input valid, input cmd, input chunk_length, input chunk_type,
                 input data_byte, output ready);
endinterface

`default_nettype wire

// File: design/pcf_rsp_if.sv
`default_nettype none

interface pcf_rsp_if
   import pcf_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] out_byte;
   logic                  chunk_end;
   logic                  error;

   modport source (output valid, output out_byte, output chunk_end, output error,
                   input ready);
   modport sink (input valid, input out_byte, input chunk_end, input error,
                 output ready);
endinterface

`default_nettype wire

// File: design/pcf_front.sv
`default_nettype none

module pcf_front
   import pcf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   pcf_req_if.sink       req_chan,
   input  wire logic     q_ready,
   output pcf_entry_type q_entry,
   output logic          q_push
);

   logic                 chunk_open_ff, chunk_open_in;
   logic [LEN_WIDTH-1:0] bytes_owed_ff, bytes_owed_in;
   logic                 accept;

   assign req_chan.ready = q_ready;
   assign accept         = req_chan.valid && q_ready;
   assign q_push         = accept;

   always_comb begin
      chunk_open_in          = chunk_open_ff;
      bytes_owed_in          = bytes_owed_ff;
      q_entry.op             = OP_ERROR;
      q_entry.chunk_length   = req_chan.chunk_length;
      q_entry.chunk_type     = req_chan.chunk_type;
      q_entry.data_byte      = req_chan.data_byte;
      if (req_chan.cmd == CMD_BEGIN) begin
         if (!chunk_open_ff) begin
            if (req_chan.chunk_length == '0) begin
               q_entry.op = OP_BEGIN_EMPTY;
            end else begin
               q_entry.op    = OP_BEGIN;
               chunk_open_in = 1'b1;
               bytes_owed_in = req_chan.chunk_length;
            end
         end
      end else if (chunk_open_ff) begin
         bytes_owed_in = bytes_owed_ff - LEN_WIDTH'(1);
         if (bytes_owed_ff == LEN_WIDTH'(1)) begin
            q_entry.op    = OP_DATA_LAST;
            chunk_open_in = 1'b0;
         end else begin
            q_entry.op = OP_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_open_ff <= 1'b0;
         bytes_owed_ff <= '0;
      end else if (accept) begin
         chunk_open_ff <= chunk_open_in;
         bytes_owed_ff <= bytes_owed_in;
      end
   end

endmodule

`default_nettype wire

// File: design/pcf_queue.sv
`default_nettype none

module pcf_queue
   import pcf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire pcf_entry_type push_entry,
   output logic               push_ready,
   input  wire logic          pop,
   output pcf_entry_type      head_entry,
   output logic               head_valid
);

   pcf_entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/pcf_back.sv
`default_nettype none

module pcf_back
   import pcf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pcf_entry_type head_entry,
   input  wire logic          head_valid,
   output logic               pop,
   pcf_rsp_if.source          rsp_chan
);

   logic                  busy_ff, busy_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   pcf_op_type            op_ff;
   logic [LEN_WIDTH-1:0]  len_ff;
   logic [TYPE_WIDTH-1:0] type_ff;
   logic [CRC_WIDTH-1:0]  crc_ff, crc_in;

   logic                  out_valid_ff;
   logic [BYTE_WIDTH-1:0] out_byte_ff;
   logic                  chunk_end_ff;
   logic                  error_ff;

   pcf_op_type            cur_op;
   logic [LEN_WIDTH-1:0]  cur_len;
   logic [TYPE_WIDTH-1:0] cur_type;
   logic [STEP_WIDTH-1:0] cur_step;
   logic [1:0]            step_m1;
   logic                  cur_valid, out_load, advance, is_last;
   logic [BYTE_WIDTH-1:0] byte_sel;
   logic                  end_sel, err_sel, fold_en;
   logic [BYTE_WIDTH-1:0] fold_byte;
   logic [CRC_WIDTH-1:0]  fold_src, crc_out;

   assign cur_op    = busy_ff ? op_ff   : head_entry.op;
   assign cur_len   = busy_ff ? len_ff  : head_entry.chunk_length;
   assign cur_type  = busy_ff ? type_ff : head_entry.chunk_type;
   assign cur_step  = busy_ff ? step_ff : '0;
   assign step_m1   = cur_step[1:0] - 2'd1;
   assign cur_valid = busy_ff || head_valid;
   assign out_load  = !out_valid_ff || rsp_chan.ready;
   assign advance   = out_load && cur_valid;
   assign pop       = advance && !busy_ff;
   assign crc_out   = crc_ff ^ CRC_ONES;

   always_comb begin
      byte_sel  = '0;
      end_sel   = 1'b0;
      err_sel   = 1'b0;
      is_last   = 1'b1;
      fold_en   = 1'b0;
      fold_byte = '0;
      fold_src  = crc_ff;
      case (cur_op)
         OP_BEGIN, OP_BEGIN_EMPTY: begin
            if (cur_step < STEP_TYPE_FIRST) begin
               byte_sel = be_byte({1'b0, cur_len}, cur_step[1:0]);
            end else if (cur_step < STEP_CRC_FIRST) begin
               byte_sel  = be_byte(cur_type, cur_step[1:0]);
               fold_en   = 1'b1;
               fold_byte = byte_sel;
               // The first type byte restarts the CRC from all ones.
               if (cur_step == STEP_TYPE_FIRST) begin
                  fold_src = CRC_ONES;
               end
            end else begin
               byte_sel = be_byte(crc_out, cur_step[1:0]);
            end
            if (cur_op == OP_BEGIN) begin
               is_last = (cur_step == STEP_BEGIN_LAST);
            end else begin
               is_last = (cur_step == STEP_EMPTY_LAST);
               end_sel = is_last;
            end
         end
         OP_DATA, OP_DATA_LAST: begin
            if (cur_step == '0) begin
               byte_sel  = head_entry.data_byte;
               fold_en   = 1'b1;
               fold_byte = head_entry.data_byte;
            end else begin
               byte_sel = be_byte(crc_out, step_m1);
            end
            if (cur_op == OP_DATA_LAST) begin
               is_last = (cur_step == STEP_DATA_LAST);
               end_sel = is_last;
            end
         end
         default: begin
            err_sel = 1'b1;
         end
      endcase
      crc_in = fold_en ? crc_fold(fold_src, fold_byte) : crc_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (advance) begin
         busy_in = !is_last;
         step_in = cur_step + STEP_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (out_load) begin
            out_valid_ff <= cur_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (advance) begin
         crc_ff       <= crc_in;
         out_byte_ff  <= byte_sel;
         chunk_end_ff <= end_sel;
         error_ff     <= err_sel;
      end
      if (pop) begin
         op_ff   <= head_entry.op;
         len_ff  <= head_entry.chunk_length;
         type_ff <= head_entry.chunk_type;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.chunk_end = chunk_end_ff;
   assign rsp_chan.error     = error_ff;

endmodule

`default_nettype wire

// File: design/png_chunk_crc_framer.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_chan  in   valid / ready      cmd, chunk_length, chunk_type, data_byte
// rsp_chan  out  valid / ready      out_byte, chunk_end, error
//
// A data transaction gives one byte, or five when it closes the chunk; a begin gives
// eight bytes, or twelve for an empty chunk; an out of sequence transaction gives one
// error byte. The rate is set by the output sequencer, which emits one byte per cycle
// while work is queued and rsp_chan accepts; each type or data byte takes one CRC lookup.
// Reset clears the chunk state, the queue and the output register; the CRC is seeded
// by every begin. Either side may stall on its own behind the four-entry queue.

module png_chunk_crc_framer
   import pcf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pcf_req_if.sink   req_chan,
   pcf_rsp_if.source rsp_chan
);

   // The front end tracks whether a chunk is open and how many data bytes it still
   // owes, so each incoming transaction is classified the cycle it arrives.
   pcf_entry_type push_entry;
   pcf_entry_type head_entry;
   logic          push;
   logic          push_ready;
   logic          head_valid;
   logic          pop;

   pcf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_ready  (push_ready),
      .q_entry  (push_entry),
      .q_push   (push)
   );

   // The queue decouples classification from byte emission, so new transactions keep
   // arriving while a multi-byte header or trailer is still being sent.
   pcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid)
   );

   // The back end walks each queued operation byte by byte, folding the type and
   // data bytes into the CRC and appending the complemented CRC big-endian.
   pcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/png_chunk_stream_checker.sv
`default_nettype none

module png_chunk_stream_checker
   import pcf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pcf_req_if        req_chan,
   pcf_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_count
);

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  chunk_end;
      logic                  error;
   } framed_byte_type;

   framed_byte_type       framed_q[$];
   logic [CRC_WIDTH-1:0]  running_crc;
   logic [LEN_WIDTH-1:0]  data_owed;
   logic                  chunk_is_open;

   // Bitwise form of the reflected CRC-32 step over one byte.
   function automatic logic [CRC_WIDTH-1:0] crc_update(input logic [CRC_WIDTH-1:0] c,
                                                      input logic [BYTE_WIDTH-1:0] b);
      logic [CRC_WIDTH-1:0] r;
      r = c ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, b};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   task automatic push_byte(input logic [BYTE_WIDTH-1:0] b, input logic last,
                            input logic err);
      framed_byte_type fb;
      fb.out_byte  = b;
      fb.chunk_end = last;
      fb.error     = err;
      framed_q.push_back(fb);
   endtask

   task automatic push_word(input logic [31:0] w, input logic last);
      push_byte(w[31:24], 1'b0, 1'b0);
      push_byte(w[23:16], 1'b0, 1'b0);
      push_byte(w[15:8], 1'b0, 1'b0);
      push_byte(w[7:0], last, 1'b0);
   endtask

   // Works out the bytes that one accepted transaction puts on the output stream.
   task automatic predict_framing(input logic cmd, input logic [LEN_WIDTH-1:0] len,
                                  input logic [TYPE_WIDTH-1:0] ctype,
                                  input logic [BYTE_WIDTH-1:0] data);
      if (cmd == CMD_BEGIN) begin
         if (chunk_is_open) begin
            push_byte('0, 1'b0, 1'b1);
         end else begin
            push_word({1'b0, len}, 1'b0);
            push_word(ctype, 1'b0);
            running_crc = CRC_ONES;
            for (int i = 3; i >= 0; i--) begin
               running_crc = crc_update(running_crc, ctype[8*i +: 8]);
            end
            if (len == '0) begin
               push_word(~running_crc, 1'b1);
            end else begin
               data_owed     = len;
               chunk_is_open = 1'b1;
            end
         end
      end else if (!chunk_is_open) begin
         push_byte('0, 1'b0, 1'b1);
      end else begin
         push_byte(data, 1'b0, 1'b0);
         running_crc = crc_update(running_crc, data);
         data_owed   = data_owed - LEN_WIDTH'(1);
         if (data_owed == '0) begin
            push_word(~running_crc, 1'b1);
            chunk_is_open = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      framed_byte_type want;
      int misses;
      misses = 0;
      if (reset) begin
         framed_q.delete();
         running_crc   = CRC_ONES;
         data_owed     = '0;
         chunk_is_open = 1'b0;
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_framing(req_chan.cmd, req_chan.chunk_length, req_chan.chunk_type,
                            req_chan.data_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (framed_q.size() == 0) begin
               $error("unexpected output byte %02h (chunk_end %b, error %b)",
                      rsp_chan.out_byte, rsp_chan.chunk_end, rsp_chan.error);
               misses++;
            end else begin
               want = framed_q.pop_front();
               if (rsp_chan.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, got %02h",
                         want.out_byte, rsp_chan.out_byte);
                  misses++;
               end
               if (rsp_chan.chunk_end !== want.chunk_end) begin
                  $error("chunk_end mismatch: expected %b, got %b",
                         want.chunk_end, rsp_chan.chunk_end);
                  misses++;
               end
               if (rsp_chan.error !== want.error) begin
                  $error("error mismatch: expected %b, got %b",
                         want.error, rsp_chan.error);
                  misses++;
               end
            end
         end
         fail_count    <= fail_count + misses;
         pending_count <= framed_q.size();
      end
   end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
   import pcf_pkg::*;

   // The random part stops once this many in-sequence transactions have been offered.
   localparam int WELL_FORMED_ITEMS = 420;
   // The limit leaves a wide margin over the slowest correct run.
   localparam int CYCLE_LIMIT       = 400000;
   // Length of the deliberate output stall that backs the block up into its input.
   localparam int LONG_HOLD         = 600;
   // Cycles watched for stray output after the last expected byte has arrived.
   localparam int TAIL_CYCLES       = 24;

   localparam logic [TYPE_WIDTH-1:0] TYPE_IHDR = 32'h49484452;
   localparam logic [TYPE_WIDTH-1:0] TYPE_IDAT = 32'h49444154;
   localparam logic [TYPE_WIDTH-1:0] TYPE_IEND = 32'h49454E44;
   localparam logic [TYPE_WIDTH-1:0] TYPE_TEXT = 32'h74455874;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   int   well_formed_sent;
   int   bytes_taken;
   bit   send_eager;
   bit   take_eager;

   pcf_req_if req_chan();
   pcf_rsp_if rsp_chan();

   png_chunk_crc_framer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   png_chunk_stream_checker stream_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Offers one transaction after a random idle gap and returns at the edge where it is
   // accepted. Valid is left high so that a back-to-back transaction never sees valid
   // lowered and raised again in the same time step.
   task automatic offer(input logic cmd, input logic [LEN_WIDTH-1:0] len,
                        input logic [TYPE_WIDTH-1:0] ctype,
                        input logic [BYTE_WIDTH-1:0] data);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= cmd;
      req_chan.chunk_length <= len;
      req_chan.chunk_type   <= ctype;
      req_chan.data_byte    <= data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // The field that a command does not use always carries random content.
   task automatic begin_chunk(input logic [LEN_WIDTH-1:0] len,
                              input logic [TYPE_WIDTH-1:0] ctype);
      offer(CMD_BEGIN, len, ctype, BYTE_WIDTH'($urandom));
   endtask

   task automatic send_data(input logic [BYTE_WIDTH-1:0] b);
      offer(CMD_DATA, LEN_WIDTH'($urandom), $urandom, b);
   endtask

   // The sender goes quiet until every predicted byte has come out. The first edge is
   // skipped so that a transaction accepted just now is already counted as pending.
   task automatic idle_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Data bytes lean toward the all-zero and all-one patterns now and then.
   function automatic logic [BYTE_WIDTH-1:0] pick_data();
      logic [BYTE_WIDTH-1:0] b;
      case ($urandom_range(0, 9))
         0:       b = 8'h00;
         1:       b = 8'hFF;
         default: b = BYTE_WIDTH'($urandom);
      endcase
      return b;
   endfunction

   function automatic logic [TYPE_WIDTH-1:0] pick_type();
      logic [TYPE_WIDTH-1:0] t;
      case ($urandom_range(0, 7))
         0:       t = TYPE_IHDR;
         1:       t = TYPE_IDAT;
         2:       t = TYPE_IEND;
         3:       t = TYPE_TEXT;
         default: t = $urandom;
      endcase
      return t;
   endfunction

   // One well-formed chunk. Now and then a begin is slipped in while data is still owed;
   // the block must flag it and carry on with the open chunk. Those carry full-range
   // lengths so that the upper length bits also get exercised.
   task automatic send_chunk(input logic [LEN_WIDTH-1:0] len);
      begin_chunk(len, pick_type());
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            begin_chunk(LEN_WIDTH'($urandom), $urandom);
         end
         send_data(pick_data());
      end
      well_formed_sent += 1 + int'(len);
   endtask

   // Stimulus: a short directed part, a long random part, and one chunk left open at
   // the largest length, which cannot be closed within the run.
   initial begin
      req_chan.valid        = 1'b0;
      req_chan.cmd          = CMD_BEGIN;
      req_chan.chunk_length = '0;
      req_chan.chunk_type   = '0;
      req_chan.data_byte    = '0;
      well_formed_sent      = 0;
      send_eager            = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A data byte before any chunk has begun is flagged as an error.
      send_data(8'h5A);
      // Empty chunks close at once with the CRC over the type alone.
      begin_chunk('0, TYPE_IEND);
      begin_chunk('0, 32'hFFFFFFFF);
      begin_chunk('0, 32'h00000000);
      // Data bytes at both extremes, and a begin at the largest length arriving while
      // the chunk is still open.
      begin_chunk(31'd3, TYPE_IHDR);
      send_data(8'h00);
      begin_chunk(31'h7FFFFFFF, $urandom);
      send_data(8'hFF);
      send_data(8'h80);
      // A one-byte chunk closes on its only data byte.
      begin_chunk(31'd1, TYPE_TEXT);
      send_data(8'h01);
      // Once the chunk has closed, a further data byte is an error again.
      send_data(8'hFF);
      send_eager = 1'b1;
      begin_chunk(31'd2, 32'h00000000);
      send_data(8'h7F);
      send_data(8'hFE);
      well_formed_sent = 12;
      idle_until_drained();

      // Random part: mostly well-formed chunks with random content and small sizes, a
      // few larger ones, with stray data bytes and full drains mixed in.
      while (well_formed_sent < WELL_FORMED_ITEMS) begin
         send_eager = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 19))
            0: send_data(pick_data());
            1: idle_until_drained();
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  send_chunk(LEN_WIDTH'($urandom_range(13, 40)));
               end else begin
                  send_chunk(LEN_WIDTH'($urandom_range(0, 12)));
               end
            end
         endcase
      end

      // The largest length opens a chunk that stays open to the end of the run.
      send_eager = 1'b0;
      begin_chunk(31'h7FFFFFFF, $urandom);
      send_data(pick_data());
      send_data(pick_data());
      begin_chunk(LEN_WIDTH'($urandom), $urandom);
      send_data(pick_data());

      idle_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("png_chunk_crc_framer regression: pass");
      end else begin
         $display("png_chunk_crc_framer regression: fail");
      end
      $finish;
   end

   // Output side. Each byte is taken after a random stall, with runs of back-to-back
   // acceptance mixed in. Twice the receiver holds off for a long stretch so that the
   // block's queue fills up and it stops taking new transactions.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      bytes_taken    = 0;
      take_eager     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = take_eager ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         bytes_taken++;
         if (bytes_taken % 50 == 0) begin
            take_eager = ($urandom_range(0, 2) == 0);
         end
         if (bytes_taken == 120 || bytes_taken == 700) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   // Watchdog: a run that hangs or loses bytes ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("png_chunk_crc_framer regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
design/pcf_pkg.sv
design/pcf_req_if.sv
design/pcf_rsp_if.sv
design/pcf_front.sv
design/pcf_queue.sv
design/pcf_back.sv
design/png_chunk_crc_framer.sv
tb/png_chunk_stream_checker.sv
tb/testbench.sv
